### hdl/sorted_id_name_table_assert.svh
// Assertion macros shared by the checker of sorted_id_name_table.
`ifndef SORTED_ID_NAME_TABLE_ASSERT_SVH
`define SORTED_ID_NAME_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define SIDT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define SIDT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/sidt_pkg.sv
`timescale 1ns / 1ps
package sidt_pkg;

    localparam int DEF_TABLE_DEPTH = 256;
    localparam int DEF_NAME_CHARS  = 8;
    localparam int KEY_W           = 32;
    localparam int NAME_W          = 64;

    typedef enum logic [1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_INSERT = 2'd1,
        FUNC_LOOKUP = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_FOUND     = 3'd3,
        ST_MISSING   = 3'd4,
        ST_CLEARED   = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE,
        S_COMPARE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PUT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]        func;
        logic [KEY_W-1:0]  key;
        logic [NAME_W-1:0] entry_name;
    } req_t;

    typedef struct packed {
        status_t           status;
        logic [NAME_W-1:0] found_name;
        logic [KEY_W-1:0]  echo_key;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic    load;
        logic    rd_probe;
        logic    step;
        logic    rd_shift;
        logic    wr_shift;
        logic    put;
        logic    set_status;
        status_t code;
        logic    emit;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] func;
        logic       in_range;
        logic       hit;
        logic       full;
        logic       shift_more;
        logic       out_free;
    } sts_t;

endpackage

### hdl/sorted_id_name_table.sv
// Sorted id-to-name table. Each request word carries func (0 clear, 1 insert,
// 2 or 3 lookup), a 32-bit key and an 8-byte name; each request gives exactly
// one response word with a status, the stored name on a found lookup (zero
// otherwise) and the key echoed back. Entries sit in one single-port memory in
// ascending key order; a request is searched by binary search, each probe
// reading the memory through its registered read port and then comparing
// the key. One request is worked at a time: a search makes at most
// ceil(log2(entries + 1)) probes, and an insert that lands moves every larger
// entry up by one place, reading and then writing each, before it writes the
// new entry. The response register lets the next request start while a
// response waits to be taken.
// The memory needs no clearing pass after reset.
`timescale 1ns / 1ps
module sorted_id_name_table
    import sidt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int NAME_CHARS  = DEF_NAME_CHARS
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    cmd_t cmd;
    sts_t sts;

    // sequencer
    sidt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // table memory, search and result registers
    sidt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .NAME_CHARS  (NAME_CHARS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

### hdl/sidt_ctrl.sv
`timescale 1ns / 1ps
module sidt_ctrl
    import sidt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (sts.func == FUNC_CLEAR)
                begin
                    state_next = S_DONE;
                end
                else if (sts.in_range)
                begin
                    state_next = S_COMPARE;
                end
                else if (sts.func == FUNC_INSERT && !sts.full)
                begin
                    state_next = S_SHIFT_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_COMPARE:
            begin
                state_next = sts.hit ? S_DONE : S_PROBE;
            end
            S_SHIFT_RD:
            begin
                state_next = sts.shift_more ? S_SHIFT_WR : S_PUT;
            end
            S_SHIFT_WR:
            begin
                state_next = S_SHIFT_RD;
            end
            S_PUT:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd       = '0;
        cmd.code  = ST_INSERTED;
        req_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                cmd.load  = req_valid;
            end
            S_PROBE:
            begin
                if (sts.func == FUNC_CLEAR)
                begin
                    cmd.set_status = 1'b1;
                    cmd.code       = ST_CLEARED;
                end
                else if (sts.in_range)
                begin
                    cmd.rd_probe = 1'b1;
                end
                else if (sts.func == FUNC_INSERT)
                begin
                    // miss on insert: refuse when full, else start the shift
                    if (sts.full)
                    begin
                        cmd.set_status = 1'b1;
                        cmd.code       = ST_FULL;
                    end
                end
                else
                begin
                    cmd.set_status = 1'b1;
                    cmd.code       = ST_MISSING;
                end
            end
            S_COMPARE:
            begin
                if (sts.hit)
                begin
                    cmd.set_status = 1'b1;
                    cmd.code = (sts.func == FUNC_INSERT) ? ST_DUPLICATE : ST_FOUND;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            S_SHIFT_RD:
            begin
                cmd.rd_shift = sts.shift_more;
            end
            S_SHIFT_WR:
            begin
                cmd.wr_shift = 1'b1;
            end
            S_PUT:
            begin
                cmd.put        = 1'b1;
                cmd.set_status = 1'b1;
                cmd.code       = ST_INSERTED;
            end
            S_DONE:
            begin
                cmd.emit = sts.out_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

endmodule

### hdl/sidt_dp.sv
`timescale 1ns / 1ps
module sidt_dp
    import sidt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int NAME_CHARS  = DEF_NAME_CHARS
)
(
    input  logic clk,
    input  logic rst_n,
    input  req_t req,
    input  cmd_t cmd,
    output sts_t sts,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] ONE_C  = CNT_W'(1);
    localparam logic [CNT_W-1:0] FULL_C = CNT_W'(TABLE_DEPTH);

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [NAME_W-1:0] name;
    } entry_t;

    // keep at most NAME_CHARS bytes, zero from the first zero byte on
    function automatic logic [NAME_W-1:0] shape_name(input logic [NAME_W-1:0] raw);
        logic [NAME_W-1:0] kept;
        logic              live;
        kept = '0;
        live = 1'b1;
        for (int i = 0; i < NAME_W / 8; i++)
        begin
            if (raw[8*i +: 8] == 8'h00)
            begin
                live = 1'b0;
            end
            if (live && (i < NAME_CHARS))
            begin
                kept[8*i +: 8] = raw[8*i +: 8];
            end
        end
        return kept;
    endfunction

    entry_t mem [TABLE_DEPTH];
    entry_t rdata_reg;

    logic [1:0]        func_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [NAME_W-1:0] name_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  lo_reg;
    logic [CNT_W-1:0]  hi_reg;
    logic [CNT_W-1:0]  sh_reg;
    logic              out_valid_reg;
    rsp_t              out_reg;
    status_t           status_reg;
    logic [NAME_W-1:0] found_reg;

    logic [CNT_W-1:0] mid;
    logic [CNT_W-1:0] sh_prev;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;

    // search midpoint and shift source
    assign mid     = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign sh_prev = sh_reg - ONE_C;

    // memory port selection
    always_comb
    begin
        rd_en   = cmd.rd_probe | cmd.rd_shift;
        rd_addr = cmd.rd_probe ? mid[IDX_W-1:0] : sh_prev[IDX_W-1:0];
        wr_en   = cmd.wr_shift | cmd.put;
        wr_addr = cmd.put ? lo_reg[IDX_W-1:0] : sh_reg[IDX_W-1:0];
        wr_data = cmd.put ? entry_t'{key: key_reg, name: name_reg} : rdata_reg;
    end

    // entry memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // item capture, search bounds, shift pointer
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= req.func;
            key_reg  <= req.key;
            name_reg <= shape_name(req.entry_name);
            lo_reg   <= '0;
            hi_reg   <= count_reg;
            sh_reg   <= count_reg;
        end
        else
        begin
            if (cmd.step)
            begin
                if (rdata_reg.key > key_reg)
                begin
                    hi_reg <= mid;
                end
                else
                begin
                    lo_reg <= mid + ONE_C;
                end
            end
            if (cmd.wr_shift)
            begin
                sh_reg <= sh_prev;
            end
        end
    end

    // result of the item
    always_ff @(posedge clk)
    begin
        if (cmd.set_status)
        begin
            status_reg <= cmd.code;
            found_reg  <= (cmd.code == ST_FOUND) ? rdata_reg.name : '0;
        end
    end

    // entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.set_status && cmd.code == ST_CLEARED)
        begin
            count_reg <= '0;
        end
        else if (cmd.put)
        begin
            count_reg <= count_reg + ONE_C;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_reg.status     <= status_reg;
            out_reg.found_name <= found_reg;
            out_reg.echo_key   <= key_reg;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // status to the controller
    always_comb
    begin
        sts.func       = func_reg;
        sts.in_range   = lo_reg < hi_reg;
        sts.hit        = rdata_reg.key == key_reg;
        sts.full       = count_reg == FULL_C;
        sts.shift_more = sh_reg > lo_reg;
        sts.out_free   = !out_valid_reg || rsp_ready;
    end

endmodule

### hdl/sidt_chk.sv
`timescale 1ns / 1ps
`include "sorted_id_name_table_assert.svh"
module sidt_chk
    import sidt_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp
);

    // a stalled response word holds
    `SIDT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "rsp changed while stalled")

    // one request at a time: no accept right after an accept
    `SIDT_ASSERT_NEXT(a_one_item, req_valid && req_ready, !req_ready, "request taken while busy")

    // name only on a found lookup
    `SIDT_ASSERT_NOW(a_name_zero, rsp_valid && rsp.status != ST_FOUND, rsp.found_name == '0, "name set without a hit")

endmodule

bind sorted_id_name_table sidt_chk u_sidt_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
